### rtl/md5_pkg.sv
// md5 package: payload types, command/status structs and step constant tables
`default_nettype none
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
  } out_item_t;

  // block byte source for a buffer write
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_t;

  typedef struct packed {
    logic      buf_we;
    logic [5:0] buf_addr;
    byte_src_t buf_src;
    logic      bits_add;
    logic      load_work;
    logic      step_en;
    logic [5:0] step_k;
    logic      fold;
    logic      restart;
  } md5_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } md5_sts_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  function automatic logic [31:0] add_const(input logic [5:0] k);
    logic [31:0] t [64];
    t = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
          32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
          32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
          32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
          32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
          32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
          32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
          32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
          32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
          32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
          32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
          32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
          32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
          32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
          32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
          32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return t[k];
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] k);
    logic [4:0] t [16];
    t = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return t[{k[5:4], k[1:0]}];
  endfunction

  // message word index for step k
  function automatic logic [3:0] msg_index(input logic [5:0] k);
    logic [3:0] kl;
    logic [3:0] g;
    kl = k[3:0];
    case (k[5:4])
      2'd0:    g = kl;
      2'd1:    g = 4'((kl << 2) + kl + 4'd1);
      2'd2:    g = 4'((kl << 1) + kl + 4'd5);
      default: g = 4'((kl << 3) - kl);
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

### rtl/md5_ctrl.sv
// md5 controller: sequences byte writes, padding, compressions and output
`default_nettype none
module md5_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire md5_pkg::in_item_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire md5_pkg::md5_sts_t sts,
  output md5_pkg::md5_cmd_t     cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PAD   = 7'b0000010,
    S_ZERO  = 7'b0000100,
    S_LEN   = 7'b0001000,
    S_COMP  = 7'b0010000,
    S_FOLD  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] addr_r, addr_nxt;
  logic [5:0] k_r, k_nxt;
  logic       last_r, last_nxt;   // message end pending
  logic       final_r, final_nxt; // compression in flight is the final one
  logic       msg_ld_r;           // word register load in progress
  logic       msg_ld_nxt;
  // set when the pad byte spilled past the length field
  logic       pad_overflow_r, pad_overflow_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    k_nxt     = k_r;
    last_nxt  = last_r;
    final_nxt = final_r;
    msg_ld_nxt = 1'b0;
    cmd       = '0;
    cmd.buf_src = md5_pkg::SRC_DATA;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_data.is_last;
          if (in_data.has_data) begin
            cmd.buf_we   = 1'b1;
            cmd.buf_addr = sts.fill;
            cmd.bits_add = 1'b1;
            if (sts.fill == 6'd63) begin
              final_nxt = 1'b0;
              cmd.load_work = 1'b1;
              k_nxt = '0;
              state_nxt = S_COMP;
            end else if (in_data.is_last) begin
              addr_nxt = 6'(sts.fill + 6'd1);
              state_nxt = S_PAD;
            end
          end else if (in_data.is_last) begin
            addr_nxt = sts.fill;
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.buf_we = 1'b1; cmd.buf_addr = addr_r; cmd.buf_src = md5_pkg::SRC_PAD;
        last_nxt = 1'b0;
        addr_nxt = 6'(addr_r + 6'd1);
        if (addr_r >= md5_pkg::LEN_START) begin
          final_nxt = 1'b0;
          state_nxt = (addr_r == 6'd63) ? S_COMP : S_ZERO;
          cmd.load_work = (addr_r == 6'd63);
          k_nxt = '0;
        end else begin
          state_nxt = (addr_r == md5_pkg::LEN_START - 6'd1) ? S_LEN : S_ZERO;
          final_nxt = 1'b1;
        end
      end
      S_ZERO: begin
        cmd.buf_we = 1'b1; cmd.buf_addr = addr_r; cmd.buf_src = md5_pkg::SRC_ZERO;
        addr_nxt = 6'(addr_r + 6'd1);
        if (!final_r && addr_r == 6'd63) begin
          cmd.load_work = 1'b1;
          k_nxt = '0;
          state_nxt = S_COMP;
        end else if (final_r && addr_r == md5_pkg::LEN_START - 6'd1) begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        cmd.buf_we = 1'b1; cmd.buf_addr = addr_r; cmd.buf_src = md5_pkg::SRC_LEN;
        addr_nxt = 6'(addr_r + 6'd1);
        if (addr_r == 6'd63) begin
          cmd.load_work = 1'b1;
          k_nxt = '0;
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        // on entry the word for step 0 is fetched; then one step per cycle
        cmd.step_k = k_r;
        if (!msg_ld_r) begin
          msg_ld_nxt = 1'b1;
        end else begin
          cmd.step_en = 1'b1;
          msg_ld_nxt = 1'b1;
          k_nxt = 6'(k_r + 6'd1);
          if (k_r == 6'd63) begin
            msg_ld_nxt = 1'b0;
            state_nxt = S_FOLD;
          end
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (final_r) begin
          state_nxt = S_OUT;
        end else if (last_r) begin
          // message end came with the 64th byte: pad a fresh block
          addr_nxt = sts.fill;
          state_nxt = S_PAD;
        end else if (pad_overflow_r) begin
          // padded first block done: zeros up to the length field
          addr_nxt = '0;
          final_nxt = 1'b1;
          state_nxt = S_ZERO;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.restart = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    pad_overflow_nxt = pad_overflow_r;
    if (state_r == S_PAD) pad_overflow_nxt = (addr_r >= md5_pkg::LEN_START);
    else if (state_r == S_FOLD) pad_overflow_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      addr_r   <= '0;
      k_r      <= '0;
      last_r   <= 1'b0;
      final_r  <= 1'b0;
      msg_ld_r <= 1'b0;
      pad_overflow_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      k_r      <= k_nxt;
      last_r   <= last_nxt;
      final_r  <= final_nxt;
      msg_ld_r <= msg_ld_nxt;
      pad_overflow_r <= pad_overflow_nxt;
    end
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_comp_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step_en && k_r != 6'd63) |=> (state_r == S_COMP))
    else $error("compression left early");
  a_fold_after: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step_en && k_r == 6'd63) |=> cmd.fold) else $error("fold missing");

endmodule
`default_nettype wire

### rtl/md5_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module md5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

### rtl/md5_dp.sv
// md5 datapath: block buffer, bit counter, working and chaining registers
`default_nettype none
module md5_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        data_byte,
  input  wire md5_pkg::md5_cmd_t cmd,
  output md5_pkg::md5_sts_t      sts,
  output md5_pkg::out_item_t     digest
);

  logic [63:0] bits_r;
  logic [31:0] ca_r, cb_r, cc_r, cd_r;
  logic [31:0] wa_r, wb_r, wc_r, wd_r;
  logic [7:0]  wbyte;
  logic [31:0] mword;
  logic [7:0]  lane_q [4];
  logic [3:0]  g_next;
  logic [5:0]  k_fetch;

  assign sts.fill = bits_r[8:3];

  always_comb begin
    case (cmd.buf_src)
      md5_pkg::SRC_DATA: wbyte = data_byte;
      md5_pkg::SRC_PAD:  wbyte = md5_pkg::PAD_BYTE;
      md5_pkg::SRC_ZERO: wbyte = '0;
      default:           wbyte = bits_r[{cmd.buf_addr[2:0], 3'b000} +: 8];
    endcase
  end

  // word fetch runs one step ahead of the compression
  assign k_fetch = cmd.step_en ? 6'(cmd.step_k + 6'd1) : cmd.step_k;
  assign g_next  = md5_pkg::msg_index(k_fetch);

  for (genvar i = 0; i < 4; i++) begin : g_lane
    md5_ram #(.WIDTH(8), .DEPTH(16)) u_lane (
      .clk(clk),
      .we(cmd.buf_we && cmd.buf_addr[1:0] == 2'(i)),
      .waddr(cmd.buf_addr[5:2]),
      .wdata(wbyte),
      .raddr(g_next),
      .rdata(lane_q[i])
    );
  end
  assign mword = {lane_q[3], lane_q[2], lane_q[1], lane_q[0]};

  logic [31:0] f, sum, rot;
  logic [4:0]  s;
  always_comb begin
    case (cmd.step_k[5:4])
      2'd0:    f = (wb_r & wc_r) | (~wb_r & wd_r);
      2'd1:    f = (wb_r & wd_r) | (wc_r & ~wd_r);
      2'd2:    f = wb_r ^ wc_r ^ wd_r;
      default: f = wc_r ^ (wb_r | ~wd_r);
    endcase
    sum = wa_r + f + md5_pkg::add_const(cmd.step_k) + mword;
    s   = md5_pkg::rot_amount(cmd.step_k);
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      ca_r <= md5_pkg::IV_A; cb_r <= md5_pkg::IV_B;
      cc_r <= md5_pkg::IV_C; cd_r <= md5_pkg::IV_D;
      wa_r <= '0; wb_r <= '0; wc_r <= '0; wd_r <= '0;
    end else begin
      if (cmd.restart) begin
        bits_r <= '0;
        ca_r <= md5_pkg::IV_A; cb_r <= md5_pkg::IV_B;
        cc_r <= md5_pkg::IV_C; cd_r <= md5_pkg::IV_D;
      end else if (cmd.bits_add) begin
        bits_r <= bits_r + 64'd8;
      end
      if (cmd.load_work) begin
        wa_r <= ca_r; wb_r <= cb_r; wc_r <= cc_r; wd_r <= cd_r;
      end else if (cmd.step_en) begin
        wa_r <= wd_r; wd_r <= wc_r; wc_r <= wb_r; wb_r <= wb_r + rot;
      end
      if (cmd.fold) begin
        ca_r <= ca_r + wa_r; cb_r <= cb_r + wb_r;
        cc_r <= cc_r + wc_r; cd_r <= cd_r + wd_r;
      end
    end
  end

  assign digest.digest_a = ca_r;
  assign digest.digest_b = cb_r;
  assign digest.digest_c = cc_r;
  assign digest.digest_d = cd_r;

  a_no_write_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_en |-> !cmd.buf_we) else $error("buffer written mid compression");
  a_no_count_fold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fold |-> !cmd.bits_add) else $error("count moved during fold");
  a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.restart |=> bits_r == 64'd0) else $error("count not cleared");

endmodule
`default_nettype wire

### rtl/md5_message_digest.sv
// md5 message digest top level: controller and datapath
`default_nettype none
// usage
// in channel: one message byte per transfer (has_data), is_last ends the
//   message; has_data 0 with is_last 1 ends an empty or already sent message
// out channel: one 128-bit digest transfer per finished message
// a byte that does not fill a block is taken in the idle state; the 64th byte of a
//   block starts a compression (one round step per cycle on the shared step
//   unit, plus a word prefetch and the chaining add), during which no byte is
//   accepted
// a message end writes pad, zeros and length one byte a cycle into the block
//   buffer, then runs one or two compressions
// the block buffer is four byte-wide rams, one per word lane, read a word a step
// reset restores the initial chaining value and a zero bit count
// while the digest waits for out_ready the block accepts no input; after the
//   digest transfer it starts over for the next message
module md5_message_digest (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire md5_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output md5_pkg::out_item_t      out_data
);

  md5_pkg::md5_cmd_t cmd;
  md5_pkg::md5_sts_t sts;

  // controller decides sequencing, datapath holds all payload state
  md5_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .sts(sts), .cmd(cmd)
  );

  md5_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .data_byte(in_data.data_byte),
    .cmd(cmd), .sts(sts), .digest(out_data)
  );

endmodule
`default_nettype wire

### tb/sv/md5_message_digest_tb.sv
// testbench for the md5 byte-stream digest: directed table plus random messages vs predictor
`default_nettype none
module md5_message_digest_tb;
  import md5_pkg::*;

  localparam int MAX_CYCLES = 2000000;
  localparam int N_RANDOM   = 1350;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  always #5 clk = ~clk;

  md5_message_digest u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor state: chaining value, block buffer, bit count
  logic [31:0] chain_q [4];
  logic [7:0]  block_q [64];
  logic [63:0] bit_count;
  out_item_t   digest_queue [$];
  int          err_count = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;      // no idling in the last part
  bit          hold_long = 1'b0;  // long receiver hold-off request
  bit          hold_done = 1'b0;  // long hold-off already requested

  localparam logic [31:0] ADD_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int SHIFTS [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                 4, 11, 16, 23, 6, 10, 15, 21};

  function automatic logic [31:0] rol(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  task automatic restart_chain();
    chain_q = '{IV_A, IV_B, IV_C, IV_D};
    bit_count = '0;
  endtask

  // one 64-step md5 compression of block_q into chain_q
  task automatic compress_block();
    logic [31:0] a, b, c, d, f, m, t;
    int g, r;
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
    for (int k = 0; k < 64; k++) begin
      r = k / 16;
      case (r)
        0: begin f = (b & c) | (~b & d); g = k; end
        1: begin f = (b & d) | (c & ~d); g = 5 * k + 1; end
        2: begin f = b ^ c ^ d; g = 3 * k + 5; end
        default: begin f = c ^ (b | ~d); g = 7 * k; end
      endcase
      g = g % 16;
      m = {block_q[4*g+3], block_q[4*g+2], block_q[4*g+1], block_q[4*g]};
      t = a + f + ADD_K[k] + m;
      a = d; d = c; c = b;
      b = b + rol(t, SHIFTS[r * 4 + k % 4]);
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
  endtask

  // advance the predictor by one accepted item, queue a digest on message end
  task automatic predict_digest(in_item_t it);
    int fill;
    logic [63:0] len;
    if (it.has_data) begin
      fill = bit_count[8:3];
      block_q[fill] = it.data_byte;
      bit_count += 64'd8;
      if (fill == 63) compress_block();
    end
    if (it.is_last) begin
      len = bit_count;
      fill = len[8:3];
      block_q[fill] = PAD_BYTE;
      fill = fill + 1;
      if (fill > 56) begin
        for (int j = fill; j < 64; j++) block_q[j] = 8'h00;
        compress_block();
        fill = 0;
      end
      for (int j = fill; j < 56; j++) block_q[j] = 8'h00;
      for (int k = 0; k < 8; k++) block_q[56 + k] = len[8*k +: 8];
      compress_block();
      digest_queue.push_back('{chain_q[0], chain_q[1], chain_q[2], chain_q[3]});
      restart_chain();
    end
  endtask

  // directed table: data, has_data, is_last, check-known flag, known digest
  typedef struct {
    in_item_t  item;
    bit        known;
    out_item_t digest;
  } dir_row_t;
  dir_row_t dir_rows [$];

  task automatic add_row(logic [7:0] db, logic hd, logic il, bit kn = 0,
                         out_item_t dg = '0);
    dir_row_t r;
    r.item = '{db, hd, il};
    r.known = kn;
    r.digest = dg;
    dir_rows.push_back(r);
  endtask

  // send one item at the falling edge, wait for its transfer
  task automatic send_item(in_item_t it, bit known, out_item_t dg);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_digest(it);
    // a typed-in digest replaces the predicted one for table rows
    if (known && it.is_last) digest_queue[$] = dg;
    @(negedge clk);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (digest_queue.size() != 0) @(negedge clk);
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 8);
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // result checker at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (digest_queue.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected digest transfer %h", out_data);
      end else begin
        out_item_t e;
        e = digest_queue.pop_front();
        if (e.digest_a !== out_data.digest_a || e.digest_b !== out_data.digest_b ||
            e.digest_c !== out_data.digest_c || e.digest_d !== out_data.digest_d) begin
          err_count++;
          if (err_count <= 10) $display("digest mismatch exp %h got %h", e, out_data);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    int len, sent;
    restart_chain();
    for (int k = 0; k < 64; k++) block_q[k] = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // empty message, then "abc"
    add_row(8'h00, 1'b0, 1'b1, 1, '{32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec});
    add_row(8'h61, 1'b1, 1'b0);
    add_row(8'h62, 1'b1, 1'b0);
    add_row(8'h63, 1'b1, 1'b1);
    // idle items, byte+end together, extremes of the byte
    add_row(8'hff, 1'b0, 1'b0);
    add_row(8'h00, 1'b1, 1'b0);
    add_row(8'hff, 1'b0, 1'b0);
    add_row(8'hff, 1'b1, 1'b1);
    add_row(8'h55, 1'b1, 1'b0);
    add_row(8'haa, 1'b1, 1'b0);
    add_row(8'h00, 1'b0, 1'b1);
    // single "a", digest known
    add_row(8'h61, 1'b1, 1'b1, 1, '{32'hb975c10c, 32'ha8b6f1c0, 32'he299c331, 32'h61267769});
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].digest);

    // random messages; lengths often around the 55/56/64 pad boundaries
    sent = 0;
    while (sent < N_RANDOM) begin
      case ($urandom_range(0, 5))
        0: len = $urandom_range(0, 3);
        1: len = $urandom_range(54, 57);
        2: len = $urandom_range(62, 66);
        3: len = $urandom_range(118, 130);
        default: len = $urandom_range(0, 40);
      endcase
      if (sent > N_RANDOM * 3 / 4) quiet = 1'b1;
      if (sent > N_RANDOM / 3 && !hold_done) begin
        hold_long = 1'b1;
        hold_done = 1'b1;
      end
      for (int k = 0; k < len; k++) begin
        it.data_byte = $urandom_range(0, 255);
        it.has_data = 1'b1;
        it.is_last = (k == len - 1) && $urandom_range(0, 1);
        send_item(it, 0, '0);
        sent++;
        if ($urandom_range(0, 15) == 0) begin
          it.data_byte = $urandom_range(0, 255);
          it.has_data = 1'b0; it.is_last = 1'b0;
          send_item(it, 0, '0);
        end
        if (it.is_last) break;
      end
      if (!it.is_last || len == 0) begin
        it.data_byte = $urandom_range(0, 255);
        it.has_data = 1'b0; it.is_last = 1'b1;
        send_item(it, 0, '0);
        sent++;
      end
      // sender pause until all digests are back, after each message in a window past the half
      if (sent > N_RANDOM / 2 && sent < N_RANDOM / 2 + 140) drain_wait();
    end

    drain_wait();
    repeat (200) @(negedge clk);
    if (err_count == 0 && digest_queue.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
